// ----- hw/rtl/slaf_pkg.sv -----
// Shared types, constants and the microcode program for the slew limited angle follower.
// Has no dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package slaf_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned RATE_W  = 17;
  localparam int unsigned CFGD_W  = 16;
  localparam int unsigned OFF_W   = 15;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned PC_W    = 4;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned QUO_BITS = 16;

  localparam logic [ANGLE_W-1:0] FULL_TURN = 16'd46080;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 16'd23040;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_MAX_RATE          = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_ACCEL         = 2'd1;
  localparam logic [IDX_W-1:0] REG_FULL_ACCEL_OFFSET = 2'd2;

  localparam logic [CFGD_W-1:0] RST_MAX_RATE          = 16'd23040;
  localparam logic [CFGD_W-1:0] RST_MAX_ACCEL         = 16'd1280;
  localparam logic [OFF_W-1:0]  RST_FULL_ACCEL_OFFSET = 15'd5760;

  localparam logic [CNT_W-1:0] LOOP_LAST = CNT_W'(QUO_BITS - 1);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_DIFF,
    OP_SHORT,
    OP_CLAMP,
    OP_MUL,
    OP_DIV,
    OP_ACCEL,
    OP_SAT,
    OP_SMUL,
    OP_ADV,
    OP_WRAP1,
    OP_WRAP2,
    OP_FAOZ
  } op_e;

  typedef enum logic [2:0] {
    CD_NEXT,
    CD_JFZ,
    CD_LOOP,
    CD_JMP,
    CD_END
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            load_cnt;
  } uword_t;

  typedef struct packed {
    logic [CFGD_W-1:0] max_rate;
    logic [CFGD_W-1:0] max_accel;
    logic [OFF_W-1:0]  full_accel_offset;
  } cfg_t;

  typedef struct packed {
    logic en;
    op_e  op;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic fao_zero;
  } status_t;

  localparam logic [PC_W-1:0] PC_ACCEL = 4'd5;
  localparam logic [PC_W-1:0] PC_FAOZ  = 4'd11;

  // The program. Step 4 repeats once per quotient bit.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{OP_DIFF,  CD_NEXT, '0,       1'b0};
      4'd1:    w = '{OP_SHORT, CD_NEXT, '0,       1'b0};
      4'd2:    w = '{OP_CLAMP, CD_JFZ,  PC_FAOZ,  1'b0};
      4'd3:    w = '{OP_MUL,   CD_NEXT, '0,       1'b1};
      4'd4:    w = '{OP_DIV,   CD_LOOP, '0,       1'b0};
      4'd5:    w = '{OP_ACCEL, CD_NEXT, '0,       1'b0};
      4'd6:    w = '{OP_SAT,   CD_NEXT, '0,       1'b0};
      4'd7:    w = '{OP_SMUL,  CD_NEXT, '0,       1'b0};
      4'd8:    w = '{OP_ADV,   CD_NEXT, '0,       1'b0};
      4'd9:    w = '{OP_WRAP1, CD_NEXT, '0,       1'b0};
      4'd10:   w = '{OP_WRAP2, CD_END,  '0,       1'b0};
      4'd11:   w = '{OP_FAOZ,  CD_JMP,  PC_ACCEL, 1'b0};
      default: w = '{OP_NOP,   CD_END,  '0,       1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/slaf_if.sv -----
// Handshake channel interfaces for ticks, results and configuration writes.
// Depends on slaf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface slaf_in_if import slaf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] target_angle;
  logic [TIME_W-1:0]  tick_time;
  modport source(output valid, output target_angle, output tick_time, input ready);
  modport sink(input valid, input target_angle, input tick_time, output ready);
endinterface

interface slaf_out_if import slaf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ANGLE_W-1:0]       needle_angle;
  logic signed [RATE_W-1:0] rotation_rate;
  modport source(output valid, output needle_angle, output rotation_rate, input ready);
  modport sink(input valid, input needle_angle, input rotation_rate, output ready);
endinterface

interface slaf_cfg_if import slaf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [CFGD_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/slaf_sequencer.sv -----
// Microcode sequencer: step counter, loop counter and jump logic over the program ROM.
// Depends on slaf_pkg for the control word and the program.
`timescale 1ns / 1ps
`default_nettype none

module slaf_sequencer import slaf_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic    hold_i,
  input  wire status_t status_i,
  output logic         busy_o,
  output ctrl_t        ctrl_o
);

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  uword_t          uw;
  logic            en;

  assign uw = ucode_rom(pc_q);
  // The last step waits while the previous result is still unclaimed.
  assign en = busy_q && !(uw.cond == CD_END && hold_i);

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (en) begin
      if (uw.load_cnt) begin
        cnt_d = LOOP_LAST;
      end
      case (uw.cond)
        CD_NEXT: pc_d = pc_q + 1'b1;
        CD_JFZ:  pc_d = status_i.fao_zero ? uw.target : pc_q + 1'b1;
        CD_LOOP: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end else begin
            pc_d = pc_q + 1'b1;
          end
        end
        CD_JMP:  pc_d = uw.target;
        CD_END:  busy_d = 1'b0;
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      cnt_q  <= cnt_d;
    end
  end

  assign busy_o = busy_q;
  assign ctrl_o = '{en: en, op: uw.op, commit: en && (uw.cond == CD_END)};

endmodule

`default_nettype wire

// ----- hw/rtl/slaf_datapath.sv -----
// Datapath of the follower: one shared 16x16 multiplier, a restoring divide step,
// adders for offset, rate and angle, and the needle state. Depends on slaf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slaf_datapath import slaf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic [ANGLE_W-1:0] target_angle_i,
  input  wire logic [TIME_W-1:0]  tick_time_i,
  input  wire cfg_t               cfg_i,
  input  wire ctrl_t              ctrl_i,
  output status_t                 status_o,
  output logic [ANGLE_W-1:0]      needle_angle_o,
  output logic signed [RATE_W-1:0] rotation_rate_o
);

  localparam logic signed [SUM_W-1:0] FT_S   = $signed({2'b00, FULL_TURN});
  localparam logic signed [SUM_W-1:0] HALF_S = $signed({2'b00, HALF_TURN});

  logic [ANGLE_W-1:0]       tgt_q, tgt_fold;
  logic [TIME_W-1:0]        time_q;
  logic signed [SUM_W-1:0]  off_q, sum_q;
  logic [OFF_W-1:0]         m_q;
  logic [PROD_W-1:0]        prod_q;
  logic [ANGLE_W-1:0]       angle_q;
  logic signed [RATE_W-1:0] rate_q;

  logic signed [SUM_W-1:0]  off_neg, acc, step_s, rate_x, mr_s, mr_neg, wrapped;
  logic [SUM_W-1:0]         off_abs;
  logic [OFF_W-1:0]         off_mag, m_next;
  logic signed [RATE_W-1:0] rate_neg;
  logic [ANGLE_W-1:0]       rate_mag;
  logic [15:0]              mul_a, mul_b;
  logic [PROD_W-1:0]        product;
  logic [15:0]              r2, r_sub, fao_x;
  logic                     ge;

  assign tgt_fold = (target_angle_i >= FULL_TURN) ? target_angle_i - FULL_TURN
                                                  : target_angle_i;

  // Offset magnitude never exceeds half a turn, so it fits the offset register width.
  assign off_neg = -off_q;
  assign off_abs = off_q[SUM_W-1] ? off_neg : off_q;
  assign off_mag = off_abs[OFF_W-1:0];
  assign m_next  = (off_mag > cfg_i.full_accel_offset) ? cfg_i.full_accel_offset : off_mag;

  assign rate_neg = -rate_q;
  assign rate_mag = rate_q[RATE_W-1] ? rate_neg[ANGLE_W-1:0] : rate_q[ANGLE_W-1:0];

  always_comb begin
    if (ctrl_i.op == OP_SMUL) begin
      mul_a = rate_mag;
      mul_b = time_q;
    end else begin
      mul_a = cfg_i.max_accel;
      mul_b = {1'b0, m_q};
    end
  end
  assign product = mul_a * mul_b;

  // One quotient bit per step; the remainder sits in the upper half of prod_q.
  assign fao_x = {1'b0, cfg_i.full_accel_offset};
  assign r2    = {prod_q[30:16], prod_q[15]};
  assign ge    = r2 >= fao_x;
  assign r_sub = r2 - fao_x;

  always_comb begin
    if (off_q > 0) begin
      acc = $signed({2'b00, prod_q[15:0]});
    end else if (off_q < 0) begin
      acc = -$signed({2'b00, prod_q[15:0]});
    end else begin
      acc = '0;
    end
  end

  assign rate_x = {rate_q[RATE_W-1], rate_q};
  assign mr_s   = $signed({2'b00, cfg_i.max_rate});
  assign mr_neg = -mr_s;
  assign step_s = rate_q[RATE_W-1] ? -$signed({2'b00, prod_q[31:16]})
                                   : $signed({2'b00, prod_q[31:16]});

  always_comb begin
    if (sum_q < 0) begin
      wrapped = sum_q + FT_S;
    end else if (sum_q >= FT_S) begin
      wrapped = sum_q - FT_S;
    end else begin
      wrapped = sum_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tgt_q  <= tgt_fold;
      time_q <= tick_time_i;
    end
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        OP_DIFF:  off_q <= $signed({2'b00, tgt_q}) - $signed({2'b00, angle_q});
        OP_SHORT: begin
          if (off_q > HALF_S) begin
            off_q <= off_q - FT_S;
          end else if (off_q <= -HALF_S) begin
            off_q <= off_q + FT_S;
          end
        end
        OP_CLAMP: m_q <= m_next;
        OP_MUL:   prod_q <= product;
        OP_DIV:   prod_q <= {(ge ? r_sub : r2), prod_q[14:0], ge};
        OP_FAOZ:  prod_q[15:0] <= cfg_i.max_accel;
        OP_ACCEL: sum_q <= rate_x + acc;
        OP_SMUL:  prod_q <= product;
        OP_ADV:   sum_q <= $signed({2'b00, angle_q}) + step_s;
        OP_WRAP1: sum_q <= wrapped;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      rate_q  <= '0;
    end else if (ctrl_i.en) begin
      if (ctrl_i.op == OP_SAT) begin
        if (sum_q > mr_s) begin
          rate_q <= mr_s[RATE_W-1:0];
        end else if (sum_q < mr_neg) begin
          rate_q <= mr_neg[RATE_W-1:0];
        end else begin
          rate_q <= sum_q[RATE_W-1:0];
        end
      end
      if (ctrl_i.op == OP_WRAP2) begin
        angle_q <= wrapped[ANGLE_W-1:0];
      end
    end
  end

  assign status_o        = '{fao_zero: (cfg_i.full_accel_offset == '0)};
  assign needle_angle_o  = wrapped[ANGLE_W-1:0];
  assign rotation_rate_o = rate_q;

endmodule

`default_nettype wire

// ----- hw/rtl/slew_limited_angle_follower.sv -----
// Each input transfer starts the microcode program; its final step commits the result. With
// full_accel_offset 0 the program skips the scaling and division steps. The 16-step restoring
// division of the acceleration scaling, run by the microcode loop step, dominates the run.
// A result waits in an output register; the next tick is taken meanwhile and stalls only
// on its final step if the previous result is still unclaimed.
// Reset (rst_ni low, asynchronous): needle angle and rate clear to 0, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module slew_limited_angle_follower import slaf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  slaf_in_if.sink    in_i,
  slaf_out_if.source out_o,
  slaf_cfg_if.sink   cfg_i
);

  // Configuration registers. Writes must arrive only while the block is idle (not enforced).
  cfg_t    cfg_q, cfg_d;
  ctrl_t   ctrl;
  status_t status;
  logic    busy;
  logic    start;
  logic    hold;
  logic    cfg_xfer;

  logic                     out_valid_q, out_valid_d;
  logic [ANGLE_W-1:0]       out_angle_q;
  logic signed [RATE_W-1:0] out_rate_q;
  logic [ANGLE_W-1:0]       dp_angle;
  logic signed [RATE_W-1:0] dp_rate;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_xfer) begin
      case (cfg_i.index)
        REG_MAX_RATE:          cfg_d.max_rate          = cfg_i.data;
        REG_MAX_ACCEL:         cfg_d.max_accel         = cfg_i.data;
        REG_FULL_ACCEL_OFFSET: cfg_d.full_accel_offset = cfg_i.data[OFF_W-1:0];
        default:               ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_rate: RST_MAX_RATE, max_accel: RST_MAX_ACCEL,
                 full_accel_offset: RST_FULL_ACCEL_OFFSET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // One tick is worked at a time; a new one is taken as soon as the program ends.
  assign in_i.ready = !busy;
  assign start      = in_i.valid && in_i.ready;
  // The final step must not overwrite a result that has not been transferred yet.
  assign hold       = out_valid_q && !out_o.ready;

  slaf_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .hold_i   (hold),
    .status_i (status),
    .busy_o   (busy),
    .ctrl_o   (ctrl)
  );

  slaf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (start),
    .target_angle_i  (in_i.target_angle),
    .tick_time_i     (in_i.tick_time),
    .cfg_i           (cfg_q),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .needle_angle_o  (dp_angle),
    .rotation_rate_o (dp_rate)
  );

  // The output register is loaded by the final step and cleared once transferred.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.commit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      out_angle_q <= dp_angle;
      out_rate_q  <= dp_rate;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.needle_angle  = out_angle_q;
  assign out_o.rotation_rate = out_rate_q;

`ifndef SYNTHESIS
  a_commit_not_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.commit |-> !hold)
    else $error("result committed over an untransferred result");
  a_start_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy)
    else $error("accepted tick did not start the program");
  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.commit))
    else $error("result appeared without a commit");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_angle_q < FULL_TURN))
    else $error("needle angle outside one turn");
`endif

endmodule

`default_nettype wire
